@@ rtl/core/dhbc_pkg.sv @@
// Package for the double-hash block counter: table geometry, status codes,
// shared item types and the hash fold helpers. No dependencies.
package dhbc_pkg;

  localparam int unsigned TableSize = 4093;
  localparam int unsigned IdxW = $clog2(TableSize);
  localparam int unsigned KeyW = 48;
  localparam int unsigned CntW = 32;
  localparam int unsigned SlotW = 12;
  localparam int unsigned QDepth = 2;
  localparam int unsigned HomeMult = 256;
  localparam int unsigned StepMult = 33;
  // Fixed-point reciprocals (scaled by 2^32) of the two hash moduli.
  localparam logic [31:0] HomeRecip = 32'((64'd1 << 32) / TableSize);
  localparam logic [31:0] StepRecip = 32'((64'd1 << 32) / (TableSize - 1));

  typedef enum logic [1:0] {
    StNew  = 2'd0,
    StInc  = 2'd1,
    StFull = 2'd2,
    StRead = 2'd3
  } status_e;

  typedef enum logic {
    OpInsert = 1'b0,
    OpRead   = 1'b1
  } opcode_e;

  // Classified work item passed from the front end to the back end.
  typedef struct packed {
    logic             is_read;
    logic             rd_in_range;
    logic [SlotW-1:0] rd_index;
    logic [KeyW-1:0]  key;
    logic [IdxW-1:0]  home;
    logic [IdxW-1:0]  step;
  } work_t;

  typedef struct packed {
    status_e          status;
    logic [SlotW-1:0] slot;
    logic             occupied;
    logic [KeyW-1:0]  stored_key;
    logic [CntW-1:0]  count;
  } result_t;

  typedef enum logic [2:0] {
    BeIdle,
    BeRead,
    BeWait,
    BeCheck,
    BeOut
  } be_state_e;

  // One fold step: (h*mult + byte) mod modulus, h below modulus. The quotient
  // estimate from the reciprocal is low by at most one, so one conditional
  // subtract finishes the reduction.
  function automatic logic [IdxW-1:0] fold_step(input logic [IdxW-1:0] h,
                                                 input logic [7:0] b,
                                                 input logic [8:0] mult,
                                                 input logic [IdxW:0] modulus,
                                                 input logic [31:0] recip);
    logic [IdxW+9:0]  acc;
    logic [IdxW+41:0] prod;
    logic [IdxW+9:0]  q;
    logic [IdxW+9:0]  r;
    acc = (IdxW+10)'(h) * (IdxW+10)'(mult) + (IdxW+10)'(b);
    prod = (IdxW+42)'(acc) * (IdxW+42)'(recip);
    q = prod[IdxW+41:32];
    r = acc - q * (IdxW+10)'(modulus);
    if (r >= (IdxW+10)'(modulus)) r = r - (IdxW+10)'(modulus);
    return r[IdxW-1:0];
  endfunction

endpackage

@@ rtl/core/double_hash_block_counter_unit.sv @@
// Top level of the double-hash block counter.
// Depends on dhbc_pkg, dhbc_front, dhbc_queue and dhbc_back.
//
// Input stream s_axis: one transaction carries an opcode, a key and a slot
// index. An insert counts the key in a 4093-slot double-hashed table; a read
// returns one slot. Output stream m_axis: one result transaction per input.
// An insert first folds its six key bytes in the front end, one a cycle, and
// is then pushed to the queue; the back end pops it and runs each probe as
// memory read, registered data, then compare and write, before its output
// state. A read skips hashing. The front end takes no new item while it is
// hashing an insert; the back end takes a new item only once the previous
// result has been taken. After reset a clearing pass over all 4093 slots
// wipes the valid marks; items queue up but are not processed until it ends.
// While m_axis_tready is low the result register holds and the back end
// waits; the front end keeps hashing into a two-entry queue until that fills.
module double_hash_block_counter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // opcode[0], key[48:1], slot_index[60:49]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata   // status[1:0], slot[13:2], occupied[14],
                                     // stored_key[62:15], count[94:63]
);
  import dhbc_pkg::*;

  logic    f_push, q_full, q_empty, q_pop, f_ready, clr_busy, rd_push;
  work_t   f_work, q_in, q_out;
  result_t res;
  logic    opc;
  logic [SlotW-1:0] idx;

  assign opc = s_axis_tdata[0];
  assign idx = s_axis_tdata[60:49];
  // Reads skip the hash and go straight to the queue.
  assign rd_push = f_ready && s_axis_tvalid && opc == OpRead && !q_full;
  assign s_axis_tready = f_ready && (opc == OpInsert || !q_full);

  always_comb begin
    q_in = f_work;
    if (rd_push) begin
      q_in = '0;
      q_in.is_read = 1'b1;
      q_in.rd_index = idx;
      q_in.home = IdxW'(idx);
      q_in.rd_in_range = {1'b0, idx} < (SlotW+1)'(TableSize);
    end
  end

  dhbc_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(f_ready),
    .opcode_i(opc), .key_i(s_axis_tdata[48:1]), .index_i(idx),
    .push_o(f_push), .work_o(f_work), .full_i(q_full)
  );

  dhbc_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(f_push || rd_push), .data_i(q_in),
    .full_o(q_full), .empty_o(q_empty), .pop_i(q_pop), .data_o(q_out)
  );

  // Reads of out-of-range slots look at slot 0; the back end reports them empty.
  work_t q_fix;
  always_comb begin
    q_fix = q_out;
    if (q_out.is_read && !q_out.rd_in_range) q_fix.home = '0;
  end

  dhbc_back u_back (
    .clk_i, .rst_ni,
    .empty_i(q_empty), .work_i(q_fix), .pop_o(q_pop), .clr_busy_o(clr_busy),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {1'b0, res.count, res.stored_key, res.occupied,
                         res.slot, res.status};

  logic unused;
  assign unused = clr_busy ^ (|s_axis_tdata[63:61]);
endmodule

@@ rtl/core/dhbc_front.sv @@
// Front end: accepts items, folds the two key hashes one byte per cycle and
// pushes classified work into the queue. Depends on dhbc_pkg.
module dhbc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      opcode_i,
  input  logic [dhbc_pkg::KeyW-1:0] key_i,
  input  logic [dhbc_pkg::SlotW-1:0] index_i,
  output logic                      push_o,
  output dhbc_pkg::work_t           work_o,
  input  logic                      full_i
);
  import dhbc_pkg::*;

  logic             busy_q, busy_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [KeyW-1:0]  key_q, shift_q, shift_d;
  logic [IdxW-1:0]  home_q, home_d, step_q, step_d;
  logic             done;
  logic [IdxW-1:0]  step_fix;
  logic [IdxW:0]    mod_home, mod_step;

  // Constant multiplications by 256 and 33 on 12-bit values; the reduction
  // is a reciprocal multiplication by a constant on a narrow value.
  assign mod_home = (IdxW+1)'(TableSize);
  assign mod_step = (IdxW+1)'(TableSize - 1);

  assign in_ready_o = !busy_q;
  assign done = busy_q && (cnt_q == 3'd6);
  assign push_o = done && !full_i;
  assign step_fix = (step_q == '0) ? IdxW'(1) : step_q;

  always_comb begin
    work_o = '0;
    work_o.is_read = 1'b0;
    work_o.key = key_q;
    work_o.home = home_q;
    work_o.step = step_fix;
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d = cnt_q;
    shift_d = shift_q;
    home_d = home_q;
    step_d = step_q;
    if (!busy_q) begin
      if (in_valid_i && opcode_i == OpInsert) begin
        busy_d = 1'b1;
        cnt_d = '0;
        shift_d = key_i;
        home_d = '0;
        step_d = '0;
      end
    end else if (cnt_q != 3'd6) begin
      home_d = fold_step(home_q, shift_q[KeyW-1 -: 8], 9'(HomeMult), mod_home, HomeRecip);
      step_d = fold_step(step_q, shift_q[KeyW-1 -: 8], 9'(StepMult), mod_step, StepRecip);
      shift_d = {shift_q[KeyW-9:0], 8'h00};
      cnt_d = cnt_q + 3'd1;
    end else if (!full_i) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    home_q <= home_d;
    step_q <= step_d;
    if (!busy_q && in_valid_i) key_q <= key_i;
  end

  logic unused_idx;
  assign unused_idx = ^index_i;
endmodule

@@ rtl/core/dhbc_queue.sv @@
// Short work queue between front end and back end. Depends on dhbc_pkg.
module dhbc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dhbc_pkg::work_t data_i,
  output logic            full_o,
  output logic            empty_o,
  input  logic            pop_i,
  output dhbc_pkg::work_t data_o
);
  import dhbc_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);
  work_t           mem_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   fill_q;

  assign full_o = fill_q == (PtrW+1)'(QDepth);
  assign empty_o = fill_q == '0;
  assign data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PtrW'(1);
      if (pop_i) rd_q <= rd_q + PtrW'(1);
      fill_q <= fill_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end
endmodule

@@ rtl/core/dhbc_back.sv @@
// Back end: probes the table memory, updates entries and forms results.
// Holds the valid bits (cleared by a pass after reset). Depends on dhbc_pkg.
module dhbc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  dhbc_pkg::work_t work_i,
  output logic            pop_o,
  output logic            clr_busy_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output dhbc_pkg::result_t res_o
);
  import dhbc_pkg::*;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [CntW-1:0] cnt;
  } entry_t;

  entry_t          mem_q [TableSize];
  logic            vmem_q [TableSize];
  entry_t          rd_data_q;
  logic            rd_valid_q;

  be_state_e       state_q, state_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [IdxW:0]   tries_q, tries_d;
  logic [IdxW-1:0] clr_q;
  logic            clr_busy_q;
  work_t           cur_q;
  result_t         res_q, res_d;
  logic            res_v_q;
  logic            wr_en;
  logic            vwr;
  entry_t          wr_data;
  logic [IdxW:0]   pos_sum;
  logic [IdxW-1:0] pos_next;

  assign clr_busy_o = clr_busy_q;
  assign res_valid_o = res_v_q;
  assign res_o = res_q;
  assign pos_sum = {1'b0, pos_q} + {1'b0, cur_q.step};
  assign pos_next = (pos_sum >= (IdxW+1)'(TableSize)) ?
                    IdxW'(pos_sum - (IdxW+1)'(TableSize)) : pos_sum[IdxW-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      BeIdle:  if (!empty_i && !clr_busy_q && !res_v_q) state_d = BeRead;
      BeRead:  state_d = BeWait;
      BeWait:  state_d = BeCheck;
      BeCheck: begin
        if (cur_q.is_read || !rd_valid_q || rd_data_q.key == cur_q.key ||
            tries_q == (IdxW+1)'(TableSize - 1)) state_d = BeOut;
        else state_d = BeRead;
      end
      BeOut:   state_d = BeIdle;
      default: state_d = BeIdle;
    endcase
  end

  always_comb begin
    pop_o = state_q == BeIdle && state_d == BeRead;
    pos_d = pos_q;
    tries_d = tries_q;
    wr_en = 1'b0;
    vwr = 1'b0;
    wr_data = '0;
    res_d = '0;
    if (pop_o) begin
      pos_d = work_i.home;
      tries_d = '0;
    end
    if (state_q == BeCheck) begin
      if (cur_q.is_read) begin
        // A read never writes the table; an out-of-range index reads as empty.
        res_d.status = StRead;
        res_d.slot = cur_q.rd_index;
        if (rd_valid_q && cur_q.rd_in_range) begin
          res_d.occupied = 1'b1;
          res_d.stored_key = rd_data_q.key;
          res_d.count = rd_data_q.cnt;
        end
      end else if (!rd_valid_q) begin
        wr_en = 1'b1;
        vwr = 1'b1;
        wr_data.key = cur_q.key;
        wr_data.cnt = CntW'(1);
        res_d.status = StNew;
        res_d.slot = SlotW'(pos_q);
        res_d.occupied = 1'b1;
        res_d.stored_key = cur_q.key;
        res_d.count = CntW'(1);
      end else if (rd_data_q.key == cur_q.key) begin
        wr_en = 1'b1;
        vwr = 1'b1;
        wr_data.key = cur_q.key;
        wr_data.cnt = (&rd_data_q.cnt) ? rd_data_q.cnt : rd_data_q.cnt + CntW'(1);
        res_d.status = StInc;
        res_d.slot = SlotW'(pos_q);
        res_d.occupied = 1'b1;
        res_d.stored_key = cur_q.key;
        res_d.count = wr_data.cnt;
      end else begin
        res_d.status = StFull;
        pos_d = pos_next;
        tries_d = tries_q + (IdxW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BeIdle;
      res_v_q <= 1'b0;
      clr_q <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      state_q <= state_d;
      if (clr_busy_q) begin
        clr_q <= clr_q + IdxW'(1);
        if (clr_q == IdxW'(TableSize - 1)) clr_busy_q <= 1'b0;
      end
      if (state_q == BeCheck && state_d == BeOut) res_v_q <= 1'b1;
      else if (res_v_q && res_ready_i) res_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= work_i;
    pos_q <= pos_d;
    tries_q <= tries_d;
    if (state_q == BeCheck && state_d == BeOut) res_q <= res_d;
  end

  // Table memory: one read port and one write port, registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[pos_q] <= wr_data;
    if (state_q == BeRead) rd_data_q <= mem_q[pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) vmem_q[clr_q] <= 1'b0;
    else if (wr_en) vmem_q[pos_q] <= vwr;
    if (state_q == BeRead) rd_valid_q <= vmem_q[pos_q];
  end
endmodule

@@ rtl/core/dhbc_checker.sv @@
// Port checker for double_hash_block_counter_unit, bound to the top level.
// Depends on dhbc_pkg for the status codes.
module dhbc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [63:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata
);
  import dhbc_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == StFull |-> m_axis_tdata[94:2] == '0)
    else $error("table-full result not zero");

  a_new_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == StNew |->
      m_axis_tdata[14] && m_axis_tdata[94:63] == 32'd1)
    else $error("new entry without count one");

  a_inc_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == StInc |-> m_axis_tdata[94:63] > 32'd1)
    else $error("increment with count below two");
endmodule

bind double_hash_block_counter_unit dhbc_checker u_dhbc_checker (.*);

@@ test/tb_double_hash_block_counter_unit.sv @@
// Self-checking testbench for double_hash_block_counter_unit: it drives random and
// directed insert and read transactions and tracks the table in its own model.
// Depends on dhbc_pkg and the RTL of the counter.
module tb_double_hash_block_counter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import dhbc_pkg::*;

  localparam int unsigned NumSlots = 4093;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned KeyPool = 24;

  typedef struct {
    opcode_e          op;
    logic [KeyW-1:0]  key;
    logic [SlotW-1:0] index;
  } req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;

  double_hash_block_counter_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the hash table.
  bit              tbl_valid [NumSlots];
  logic [KeyW-1:0] tbl_key   [NumSlots];
  logic [CntW-1:0] tbl_count [NumSlots];

  req_t      pending_items[$];
  result_t   expected_results[$];
  logic [KeyW-1:0] key_pool[KeyPool];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit        quiet = 1'b0;
  bit        long_hold_req = 1'b0;
  bit        long_hold_done = 1'b0;

  function automatic int unsigned fold_hash(logic [KeyW-1:0] key, int unsigned mult,
                                            int unsigned modulus);
    longint unsigned h;
    h = 0;
    for (int b = 5; b >= 0; b--) begin
      h = (h * mult + key[8*b +: 8]) % modulus;
    end
    return int'(h);
  endfunction

  // Applies one accepted item to the shadow table and returns its result.
  function automatic result_t count_key(req_t r);
    result_t res;
    int unsigned home;
    int unsigned step;
    int unsigned pos;
    res = '{status: StFull, slot: '0, occupied: 1'b0, stored_key: '0, count: '0};
    if (r.op == OpRead) begin
      res.status = StRead;
      res.slot = r.index;
      if (r.index < NumSlots && tbl_valid[r.index]) begin
        res.occupied = 1'b1;
        res.stored_key = tbl_key[r.index];
        res.count = tbl_count[r.index];
      end
      return res;
    end
    home = fold_hash(r.key, 256, NumSlots);
    step = fold_hash(r.key, 33, NumSlots - 1);
    if (step == 0) step = 1;
    for (int unsigned i = 0; i < NumSlots; i++) begin
      pos = (home + i * step) % NumSlots;
      if (!tbl_valid[pos]) begin
        tbl_valid[pos] = 1'b1;
        tbl_key[pos] = r.key;
        tbl_count[pos] = 1;
        res = '{status: StNew, slot: pos[SlotW-1:0], occupied: 1'b1,
                stored_key: r.key, count: 1};
        return res;
      end
      if (tbl_key[pos] == r.key) begin
        if (tbl_count[pos] != '1) tbl_count[pos]++;
        res = '{status: StInc, slot: pos[SlotW-1:0], occupied: 1'b1,
                stored_key: r.key, count: tbl_count[pos]};
        return res;
      end
    end
    return res;
  endfunction

  // Sender: presents the head of the pending queue, with random idle bursts.
  int unsigned send_idle = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(count_key(pending_items.pop_front()));
      end
      if (!quiet && send_idle == 0 && $urandom_range(0, 11) == 0) begin
        send_idle = $urandom_range(1, 8);
      end
      if (send_idle > 0) begin
        send_idle--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b0, pending_items[0].index, pending_items[0].key,
                         pending_items[0].op};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: checks each result transaction and applies back-pressure.
  int unsigned recv_hold = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = status_e'(m_axis_tdata[1:0]);
        got.slot = m_axis_tdata[13:2];
        got.occupied = m_axis_tdata[14];
        got.stored_key = m_axis_tdata[62:15];
        got.count = m_axis_tdata[94:63];
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.slot != want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, got.slot);
            fail_count++;
          end
          if (got.occupied != want.occupied) begin
            $error("occupied: expected %0d, got %0d", want.occupied, got.occupied);
            fail_count++;
          end
          if (got.stored_key != want.stored_key) begin
            $error("stored_key: expected %h, got %h", want.stored_key, got.stored_key);
            fail_count++;
          end
          if (got.count != want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            fail_count++;
          end
        end
      end
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        recv_hold = 400;
      end else if (!quiet && recv_hold == 0 && $urandom_range(0, 9) == 0) begin
        recv_hold = $urandom_range(1, 8);
      end
      if (recv_hold > 0) begin
        recv_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_insert(logic [KeyW-1:0] key);
    pending_items.push_back('{op: OpInsert, key: key, index: 12'($urandom)});
  endtask

  task automatic push_read(logic [SlotW-1:0] index);
    pending_items.push_back('{op: OpRead, key: KeyW'({$urandom, $urandom}), index: index});
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || expected_results.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    logic [KeyW-1:0] k;
    int unsigned pick;
    for (int i = 0; i < KeyPool; i++) key_pool[i] = KeyW'({$urandom, $urandom});
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty and out-of-range reads, extreme keys, repeats.
    push_read(12'd0);
    push_read(12'd4092);
    push_read(12'd4093);
    push_read(12'hFFF);
    push_insert('0);
    push_insert('1);
    push_insert('0);
    push_insert('1);
    push_insert('1);
    push_insert(48'h0000_0000_0001);
    push_insert(48'h8000_0000_0000);
    push_insert(48'hFF00_FF00_FF00);
    push_read(12'(fold_hash('0, 256, NumSlots)));
    push_read(12'(fold_hash('1, 256, NumSlots)));
    // Keys that share a home slot force a second probe.
    push_insert(48'(NumSlots));
    push_insert(48'(2 * NumSlots));
    push_insert(48'(NumSlots));
    push_read(12'd0);
    wait_drained();

    for (int n = 0; n < 400; n++) begin
      if (n == 120) long_hold_req = 1'b1;
      if (n == 250) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        push_insert(key_pool[$urandom_range(0, KeyPool - 1)]);
      end else if (pick < 70) begin
        k = KeyW'({$urandom, $urandom});
        push_insert(k);
      end else if (pick < 88) begin
        k = key_pool[$urandom_range(0, KeyPool - 1)];
        push_read(12'(fold_hash(k, 256, NumSlots)));
      end else begin
        push_read(12'($urandom_range(0, 4095)));
      end
    end
    wait_drained();

    // Closing stretch without idling: fresh keys, repeats and reads.
    quiet = 1'b1;
    for (int unsigned i = 0; i < 16; i++) begin
      push_insert({16'hA5C3, 32'(i)});
    end
    push_insert(key_pool[0]);
    push_insert('1);
    push_read(12'd0);
    push_read(12'd4092);
    push_read(12'hFFE);
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/dhbc_pkg.sv
rtl/core/dhbc_front.sv
rtl/core/dhbc_queue.sv
rtl/core/dhbc_back.sv
rtl/core/double_hash_block_counter_unit.sv
rtl/core/dhbc_checker.sv
test/tb_double_hash_block_counter_unit.sv
